// ===== rtl/core/hbas_pkg.sv =====
// shared types and constants for the h-bridge actuator supervisor
package hbas_pkg;

    localparam int DEFAULT_NUM_ACTUATORS = 7;
    localparam int MAX_ACTUATORS = 16;
    localparam int EXT_W = 5;
    localparam int MASK_W = 7;

    localparam int CMD_W = 2;
    localparam int IDX_PORT_W = 3;
    localparam int CODE_W = 2;
    localparam int TIME_W = 32;
    localparam int VOLT_W = 15;
    localparam int CUR_W = 16;
    localparam int LIMIT_W = 15;
    localparam int STATE_W = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 15;
    localparam int MS_W = 10;

    localparam logic [CMD_W-1:0] CMD_ACTUATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [STATE_W-1:0] ST_STOPPED = 2'd0;
    localparam logic [STATE_W-1:0] ST_EXTEND = 2'd1;
    localparam logic [STATE_W-1:0] ST_RETRACT = 2'd2;
    localparam logic [STATE_W-1:0] ST_FAULT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] OC_REG_COUNT = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_CURRENT = 4'd7;

    localparam logic [MS_W-1:0] US_PER_MS = 10'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32767;

    typedef struct packed {
        logic                     tick;
        logic                     cmd_hit;
        logic                     sample_hit;
        logic [CODE_W-1:0]        code;
        logic [TIME_W-1:0]        dur;
        logic [TIME_W-1:0]        now_us;
        logic [TIME_W-1:0]        now_next;
        logic signed [CUR_W-1:0]  cur;
        logic [LIMIT_W-1:0]       stop_level;
    } cell_op_t;

endpackage

// ===== rtl/core/hbas_act_cell.sv =====
// per-actuator motion state, stop timer and current checks
module hbas_act_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hbas_pkg::cell_op_t            op,
    input  logic [hbas_pkg::LIMIT_W-1:0]  oc_limit,
    output logic [hbas_pkg::STATE_W-1:0]  state_next,
    output logic                          expired
);
    import hbas_pkg::*;

    logic [STATE_W-1:0] state_reg;
    logic               armed_reg;
    logic               armed_next;
    logic [TIME_W-1:0]  deadline_reg;
    logic [TIME_W-1:0]  deadline_next;
    logic [TIME_W-1:0]  diff;
    logic               over;
    logic               under;
    logic               moving;

    assign diff = op.now_next - deadline_reg;
    assign over = op.cur > $signed({1'b0, oc_limit});
    assign under = op.cur < $signed({1'b0, op.stop_level});
    assign moving = (state_reg == ST_EXTEND) || (state_reg == ST_RETRACT);
    assign expired = op.tick && armed_reg && !diff[TIME_W-1];

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg;
        deadline_next = deadline_reg;
        if (expired)
        begin
            state_next = ST_STOPPED;
            armed_next = 1'b0;
        end
        if (op.cmd_hit)
        begin
            state_next = op.code[0] ? ST_EXTEND : ST_RETRACT;
            if (op.code[1])
            begin
                deadline_next = armed_reg ? (deadline_reg + op.dur) : (op.now_us + op.dur);
                armed_next = 1'b1;
            end
        end
        if (op.sample_hit)
        begin
            if (over)
            begin
                state_next = ST_FAULT;
                armed_next = 1'b0;
            end
            else if (moving && under)
            begin
                state_next = ST_STOPPED;
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STOPPED;
            armed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
    end

endmodule

// ===== rtl/core/hbridge_actuator_supervisor_core.sv =====
// top level of the h-bridge actuator supervisor
// usage:
// - input channel (in_valid/in_ready) takes one item per transaction: an actuate
//   command, a current sample or a one microsecond tick
// - output channel (out_valid/out_ready) gives one result per command, sample
//   and tick; kind 3 items and out-of-range actuators give no result
// - cfg channel (cfg_valid/cfg_ready) writes the per-actuator trip levels and the
//   end-of-travel level; cfg_ready is always high, write only while idle
// - the path from input transaction to result valid is one input register, then
//   the state update and result register
// - throughput is one item per cycle when the output does not stall, set by the
//   single update pass over all actuator cells in parallel
// - when out_ready is low the result register holds and one more item waits in
//   the input register; in_ready drops only when both are full
// - reset stops all actuators, disarms all timers, clears the microsecond clock
//   and sets trip levels to full scale and the end-of-travel level to zero
module hbridge_actuator_supervisor_core #(
    parameter int NUM_ACTUATORS = hbas_pkg::DEFAULT_NUM_ACTUATORS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hbas_pkg::CMD_W-1:0]          cmd,
    input  logic [hbas_pkg::IDX_PORT_W-1:0]     actuator_index,
    input  logic [hbas_pkg::CODE_W-1:0]         action_code,
    input  logic [hbas_pkg::TIME_W-1:0]         run_ms,
    input  logic [hbas_pkg::VOLT_W-1:0]         bus_voltage_mv,
    input  logic signed [hbas_pkg::CUR_W-1:0]   current_ma,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hbas_pkg::IDX_PORT_W-1:0]     act_index,
    output logic [hbas_pkg::STATE_W-1:0]        act_state,
    output logic                                drive_fwd,
    output logic                                drive_rev,
    output logic [hbas_pkg::MASK_W-1:0]         stopped_mask,
    output logic                                telemetry_valid,
    output logic [hbas_pkg::VOLT_W-1:0]         report_voltage_mv,
    output logic signed [hbas_pkg::CUR_W-1:0]   report_current_ma,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hbas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbas_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import hbas_pkg::*;

    localparam int IDX_W = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;

    // input register
    logic                    s1_valid_reg;
    logic [CMD_W-1:0]        s1_cmd_reg;
    logic [IDX_PORT_W-1:0]   s1_index_reg;
    logic [CODE_W-1:0]       s1_code_reg;
    logic [TIME_W-1:0]       s1_dur_reg;
    logic [VOLT_W-1:0]       s1_volt_reg;
    logic signed [CUR_W-1:0] s1_cur_reg;
    logic [TIME_W+MS_W-1:0]  dur_full;

    // shared state
    logic [TIME_W-1:0]       now_reg;
    logic [TIME_W-1:0]       now_next;
    logic [LIMIT_W-1:0]      oc_limit_reg [NUM_ACTUATORS];
    logic [LIMIT_W-1:0]      stop_current_reg;

    // result register
    logic                    out_valid_reg;
    logic [IDX_PORT_W-1:0]   act_index_reg;
    logic [STATE_W-1:0]      act_state_reg;
    logic [MASK_W-1:0]       stopped_mask_reg;
    logic                    telemetry_valid_reg;
    logic [VOLT_W-1:0]       report_voltage_reg;
    logic signed [CUR_W-1:0] report_current_reg;

    logic                    s2_free;
    logic                    fire;
    logic                    in_take;
    logic                    cfg_take;
    logic [EXT_W-1:0]        idx_ext;
    logic [EXT_W-1:0]        cfg_idx_ext;
    logic                    idx_ok;
    logic                    has_result;
    logic                    is_tick;
    logic [IDX_W-1:0]        sel;
    logic [STATE_W-1:0]      rep_state;
    logic [STATE_W-1:0]      cell_state [NUM_ACTUATORS];
    logic [NUM_ACTUATORS-1:0] cell_expired;
    logic [MASK_W-1:0]       mask_w;
    hbas_pkg::cell_op_t      cell_op [NUM_ACTUATORS];

    logic [IDX_PORT_W-1:0]   res_index;
    logic [STATE_W-1:0]      res_state;
    logic [MASK_W-1:0]       res_mask;
    logic                    res_tv;
    logic [VOLT_W-1:0]       res_volt;
    logic signed [CUR_W-1:0] res_cur;

    assign s2_free = !out_valid_reg || out_ready;
    assign fire = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_take = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_take = cfg_valid && cfg_ready;

    assign dur_full = run_ms * US_PER_MS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg <= cmd;
            s1_index_reg <= actuator_index;
            s1_code_reg <= action_code;
            s1_dur_reg <= dur_full[TIME_W-1:0];
            s1_volt_reg <= bus_voltage_mv;
            s1_cur_reg <= current_ma;
        end
    end

    assign idx_ext = EXT_W'(s1_index_reg);
    assign cfg_idx_ext = EXT_W'(cfg_index);
    assign idx_ok = idx_ext < EXT_W'(NUM_ACTUATORS);
    assign is_tick = s1_cmd_reg == CMD_TICK;
    assign has_result = is_tick
        || (((s1_cmd_reg == CMD_ACTUATE) || (s1_cmd_reg == CMD_SAMPLE)) && idx_ok);
    assign now_next = now_reg + TIME_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            stop_current_reg <= '0;
        end
        else
        begin
            if (fire && is_tick)
            begin
                now_reg <= now_next;
            end
            if (cfg_take && (cfg_index == REG_STOP_CURRENT))
            begin
                stop_current_reg <= cfg_data;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_ACTUATORS; gi++)
        begin : g_act
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    oc_limit_reg[gi] <= LIMIT_RESET;
                end
                else if (cfg_take && (cfg_index < OC_REG_COUNT)
                         && (cfg_idx_ext == EXT_W'(gi)))
                begin
                    oc_limit_reg[gi] <= cfg_data;
                end
            end

            always_comb
            begin
                cell_op[gi].tick = fire && is_tick;
                cell_op[gi].cmd_hit = fire && (s1_cmd_reg == CMD_ACTUATE)
                    && (idx_ext == EXT_W'(gi));
                cell_op[gi].sample_hit = fire && (s1_cmd_reg == CMD_SAMPLE)
                    && (idx_ext == EXT_W'(gi));
                cell_op[gi].code = s1_code_reg;
                cell_op[gi].dur = s1_dur_reg;
                cell_op[gi].now_us = now_reg;
                cell_op[gi].now_next = now_next;
                cell_op[gi].cur = s1_cur_reg;
                cell_op[gi].stop_level = stop_current_reg;
            end

            hbas_act_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (cell_op[gi]),
                .oc_limit   (oc_limit_reg[gi]),
                .state_next (cell_state[gi]),
                .expired    (cell_expired[gi])
            );
        end

        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < NUM_ACTUATORS)
            begin : g_live
                assign mask_w[gi] = cell_expired[gi];
            end
            else
            begin : g_none
                assign mask_w[gi] = 1'b0;
            end
        end
    endgenerate

    assign sel = idx_ext[IDX_W-1:0];
    assign rep_state = idx_ok ? cell_state[sel] : ST_STOPPED;

    always_comb
    begin
        res_index = '0;
        res_state = ST_STOPPED;
        res_mask = '0;
        res_tv = 1'b0;
        res_volt = '0;
        res_cur = '0;
        unique case (s1_cmd_reg)
            CMD_TICK:
            begin
                res_mask = mask_w;
            end
            CMD_ACTUATE:
            begin
                res_index = s1_index_reg;
                res_state = rep_state;
            end
            CMD_SAMPLE:
            begin
                res_index = s1_index_reg;
                res_state = rep_state;
                res_tv = 1'b1;
                res_volt = s1_volt_reg;
                res_cur = s1_cur_reg;
            end
            default:
            begin
                res_index = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            out_valid_reg <= s1_valid_reg && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            act_index_reg <= res_index;
            act_state_reg <= res_state;
            stopped_mask_reg <= res_mask;
            telemetry_valid_reg <= res_tv;
            report_voltage_reg <= res_volt;
            report_current_reg <= res_cur;
        end
    end

    assign out_valid = out_valid_reg;
    assign act_index = act_index_reg;
    assign act_state = act_state_reg;
    assign drive_fwd = act_state_reg == ST_EXTEND;
    assign drive_rev = act_state_reg == ST_RETRACT;
    assign stopped_mask = stopped_mask_reg;
    assign telemetry_valid = telemetry_valid_reg;
    assign report_voltage_mv = report_voltage_reg;
    assign report_current_ma = report_current_reg;

endmodule

// ===== rtl/core/hbas_checker.sv =====
// port-level checks for the h-bridge actuator supervisor, bound to the top level
module hbas_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [hbas_pkg::IDX_PORT_W-1:0]     act_index,
    input  logic [hbas_pkg::STATE_W-1:0]        act_state,
    input  logic                                drive_fwd,
    input  logic                                drive_rev,
    input  logic [hbas_pkg::MASK_W-1:0]         stopped_mask,
    input  logic                                telemetry_valid
);
    import hbas_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(act_state) && $stable(act_index))
        else $error("result changed while stalled");

    // a fresh result traces back to an accepted input transaction
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input transaction");

    // bridge pins follow the reported state
    a_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_fwd == (act_state == ST_EXTEND))
                      && (drive_rev == (act_state == ST_RETRACT)))
        else $error("bridge pins disagree with state");

    // deadline stops appear only on tick results
    a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stopped_mask != '0) |->
            !telemetry_valid && (act_state == ST_STOPPED) && (act_index == '0))
        else $error("stop mask on a non-tick result");

endmodule

bind hbridge_actuator_supervisor_core hbas_checker u_hbas_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .act_index       (act_index),
    .act_state       (act_state),
    .drive_fwd       (drive_fwd),
    .drive_rev       (drive_rev),
    .stopped_mask    (stopped_mask),
    .telemetry_valid (telemetry_valid)
);
